// ----- hdl/fbpa_pkg.sv -----
package fbpa_pkg;

    localparam int DEFAULT_MAX_BLOCKS = 64;
    localparam int POOL_RESET         = 64;
    localparam int IDX_W              = 6;
    localparam int CNT_W              = 7;
    localparam int LEN_W              = 16;
    localparam int WANT_W             = 32;
    localparam int FAIL_W             = 32;
    localparam int IN_W               = 40;
    localparam int OUT_W              = 80;

    localparam logic [LEN_W-1:0] BYTES_RESET = 16'd2048;

    typedef enum logic [1:0] {
        REQ_ACQUIRE = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_SET_LEN = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    typedef enum logic {
        CFG_POOL_BLOCKS = 1'b0,
        CFG_BLOCK_BYTES = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

// ----- hdl/fbpa_ram.sv -----
module fbpa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  fbpa_pkg::t_mem_ctl   i_ctl,
    input  logic [AW-1:0]        i_rd_addr,
    output logic [WIDTH-1:0]     o_rd_data,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [WIDTH-1:0]     i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/fixed_block_pool_allocator_top.sv -----
// Channel   Direction  Handshake               Payload
// s         in         s_tvalid / s_tready     s_tdata: request word
// m         out        m_tvalid / m_tready     m_tdata: result word
// cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A request has two steps: one reads the free stack and the busy flags,
// the next updates them and loads the result register. The result register frees
// the input side, so the next word is taken while a result waits; the update
// cycle holds only while the result register is still full.
// After reset and after each pool_blocks write, a pass over every entry clears
// the busy flag memory, one entry a cycle, with s_tready low.
module fixed_block_pool_allocator_top #(
    parameter int MAX_BLOCKS = fbpa_pkg::DEFAULT_MAX_BLOCKS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // req_type[1:0], block_index[7:2], requested_length[39:8]
    input  logic [fbpa_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // status[1:0], granted_index[7:2], stored_length[23:8], free_blocks[30:24],
    // used_blocks[37:31], peak_used[44:38], failed_acquires[76:45], zeros above
    output logic [fbpa_pkg::OUT_W-1:0] m_tdata,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [15:0]                i_cfg_data
);
    import fbpa_pkg::*;

    localparam int IW        = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int DW        = $clog2(MAX_BLOCKS + 1);
    localparam int POOL_INIT = (POOL_RESET > MAX_BLOCKS) ? MAX_BLOCKS : POOL_RESET;

    t_state               r_state, n_state;
    logic [IW-1:0]        r_clr_addr;
    logic [DW-1:0]        r_pool, n_pool;
    logic [LEN_W-1:0]     r_bytes;
    logic [DW-1:0]        r_depth, n_depth;
    logic [DW-1:0]        r_low, n_low;
    logic [DW-1:0]        r_peak, n_peak;
    logic [FAIL_W-1:0]    r_fail, n_fail;
    t_req                 r_req;
    logic [IDX_W-1:0]     r_idx;
    logic [WANT_W-1:0]    r_want;
    logic                 r_pop_init;
    logic [IW-1:0]        r_pop_val;
    logic                 r_m_valid;
    logic [OUT_W-1:0]     r_m_data;

    t_mem_ctl             stk_ctl, bsy_ctl;
    logic [IW-1:0]        stk_rd_addr, stk_wr_addr, stk_rd_data;
    logic [IW-1:0]        bsy_rd_addr, bsy_wr_addr;
    logic                 bsy_wr_data, bsy_rd_data;

    logic                 s_fire, cfg_fire, pool_wr, exec_go;
    logic [6:0]           cfg_v7;
    logic [IW-1:0]        pop_top;
    logic                 valid_idx;
    t_status              res_status;
    logic [IDX_W-1:0]     res_granted;
    logic [LEN_W-1:0]     res_len;
    logic [DW-1:0]        used_new;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid;
    assign pool_wr     = cfg_fire && (t_cfg_reg'(i_cfg_index) == CFG_POOL_BLOCKS);
    assign cfg_v7      = i_cfg_data[6:0];
    assign s_fire      = s_tvalid && s_tready;
    assign exec_go     = (r_state == S_EXEC) && (!r_m_valid || m_tready);

    always_comb begin
        if (cfg_v7 == 7'd0) begin
            n_pool = DW'(1);
        end else if (int'(cfg_v7) > MAX_BLOCKS) begin
            n_pool = DW'(MAX_BLOCKS);
        end else begin
            n_pool = DW'(cfg_v7);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == IW'(MAX_BLOCKS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
        if (pool_wr) begin
            n_state = S_CLEAR;
        end
    end

    assign pop_top   = r_pop_init ? r_pop_val : stk_rd_data;
    assign valid_idx = (32'(r_idx) < 32'(r_pool)) && (32'(r_idx) < MAX_BLOCKS);
    assign used_new  = r_pool - n_depth;

    always_comb begin
        s_tready      = (r_state == S_IDLE);
        stk_ctl.rd_en = s_fire;
        stk_ctl.wr_en = 1'b0;
        stk_rd_addr   = IW'(r_depth - DW'(1));
        stk_wr_addr   = IW'(r_depth);
        bsy_ctl.rd_en = s_fire;
        bsy_ctl.wr_en = 1'b0;
        bsy_rd_addr   = IW'(s_tdata[7:2]);
        bsy_wr_addr   = r_clr_addr;
        bsy_wr_data   = 1'b0;
        n_depth       = r_depth;
        n_low         = r_low;
        n_peak        = r_peak;
        n_fail        = r_fail;
        res_status    = ST_INVALID;
        res_granted   = r_idx;
        res_len       = '0;

        unique case (r_req)
            REQ_ACQUIRE: begin
                res_granted = '0;
                if (r_depth == '0) begin
                    res_status = ST_NO_FREE;
                    if (r_fail != '1) begin
                        n_fail = r_fail + FAIL_W'(1);
                    end
                end else begin
                    res_status  = ST_OK;
                    res_granted = IDX_W'(pop_top);
                    n_depth     = r_depth - DW'(1);
                    bsy_wr_addr = pop_top;
                    bsy_wr_data = 1'b1;
                    bsy_ctl.wr_en = exec_go;
                    if (r_pop_init) begin
                        n_low = n_depth;
                    end
                end
            end
            REQ_RELEASE: begin
                if (valid_idx && bsy_rd_data && (r_depth < r_pool)) begin
                    res_status    = ST_OK;
                    n_depth       = r_depth + DW'(1);
                    bsy_wr_addr   = IW'(r_idx);
                    bsy_wr_data   = 1'b0;
                    bsy_ctl.wr_en = exec_go;
                    stk_ctl.wr_en = exec_go;
                end
            end
            REQ_SET_LEN: begin
                if (valid_idx && bsy_rd_data) begin
                    res_status = ST_OK;
                    res_len    = (r_want <= WANT_W'(r_bytes)) ? LEN_W'(r_want) : r_bytes;
                end
            end
            default: res_status = ST_INVALID;
        endcase

        if (r_state == S_CLEAR) begin
            bsy_ctl.wr_en = 1'b1;
            bsy_wr_addr   = r_clr_addr;
            bsy_wr_data   = 1'b0;
        end

        if (used_new > r_peak) begin
            n_peak = used_new;
        end
    end

    fbpa_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_BLOCKS)
    ) u_stack (
        .i_clk     (i_clk),
        .i_ctl     (stk_ctl),
        .i_rd_addr (stk_rd_addr),
        .o_rd_data (stk_rd_data),
        .i_wr_addr (stk_wr_addr),
        .i_wr_data (IW'(r_idx))
    );

    fbpa_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BLOCKS)
    ) u_busy (
        .i_clk     (i_clk),
        .i_ctl     (bsy_ctl),
        .i_rd_addr (bsy_rd_addr),
        .o_rd_data (bsy_rd_data),
        .i_wr_addr (bsy_wr_addr),
        .i_wr_data (bsy_wr_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_pool     <= DW'(POOL_INIT);
            r_bytes    <= BYTES_RESET;
            r_depth    <= DW'(POOL_INIT);
            r_low      <= DW'(POOL_INIT);
            r_peak     <= '0;
            r_fail     <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (pool_wr) begin
                r_clr_addr <= '0;
            end else if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + IW'(1);
            end
            if (exec_go) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
            if (cfg_fire && (t_cfg_reg'(i_cfg_index) == CFG_BLOCK_BYTES)) begin
                r_bytes <= i_cfg_data;
            end
            if (pool_wr) begin
                r_pool     <= n_pool;
                r_depth    <= n_pool;
                r_low      <= n_pool;
                r_peak     <= '0;
                r_fail     <= '0;
            end else if (exec_go) begin
                r_depth   <= n_depth;
                r_low     <= n_low;
                r_peak    <= n_peak;
                r_fail    <= n_fail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_req      <= t_req'(s_tdata[1:0]);
            r_idx      <= s_tdata[7:2];
            r_want     <= s_tdata[39:8];
            r_pop_init <= (r_depth <= r_low);
            r_pop_val  <= IW'(r_pool - r_depth);
        end
        if (exec_go) begin
            r_m_data <= {3'b000, n_fail, CNT_W'(n_peak), CNT_W'(used_new),
                         CNT_W'(n_depth), res_len, res_granted, res_status};
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

endmodule

// ----- tb/tb_fixed_block_pool_allocator_top.sv -----
module tb_fixed_block_pool_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fbpa_pkg::*;

    localparam int MAXB = DEFAULT_MAX_BLOCKS;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [WANT_W-1:0] want;
        logic [IDX_W-1:0]  idx;
        logic [1:0]        req;
    } t_request;

    typedef struct packed {
        logic [FAIL_W-1:0] fails;
        logic [CNT_W-1:0]  peak;
        logic [CNT_W-1:0]  used;
        logic [CNT_W-1:0]  free;
        logic [LEN_W-1:0]  len;
        logic [IDX_W-1:0]  granted;
        logic [1:0]        status;
    } t_result;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata     = '0;
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_index = 1'b0;
    logic [15:0]       i_cfg_data  = '0;

    fixed_block_pool_allocator_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    logic [IDX_W-1:0]  pool_stack [MAXB];
    bit                pool_busy  [MAXB];
    logic [LEN_W-1:0]  pool_len   [MAXB];
    int                pool_size;
    int                pool_depth;
    int                pool_peak;
    logic [FAIL_W-1:0] pool_refused;
    logic [LEN_W-1:0]  blk_bytes;

    t_request pending_reqs [$];
    t_result  expected_replies [$];
    t_result  exp_r;
    t_result  got_r;
    bit       req_taken;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       errors;
    int       n_reqs;
    int       n_cfg;
    int       n_ok;
    int       n_nofree;
    int       n_invalid;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void pool_reinit();
        for (int i = 0; i < MAXB; i++) begin
            pool_stack[i] = '0;
            pool_busy[i]  = 1'b0;
            pool_len[i]   = '0;
        end
        for (int i = 0; i < pool_size; i++) begin
            pool_stack[i] = IDX_W'(pool_size - 1 - i);
        end
        pool_depth   = pool_size;
        pool_peak    = 0;
        pool_refused = '0;
    endfunction

    function automatic void apply_reg(t_cfg_reg sel, logic [15:0] val);
        int n;
        if (sel == CFG_POOL_BLOCKS) begin
            n = int'(val[6:0]);
            if (n == 0) n = 1;
            if (n > MAXB) n = MAXB;
            pool_size = n;
            pool_reinit();
        end else begin
            blk_bytes = val;
        end
    endfunction

    function automatic t_result predict_reply(t_request rq);
        t_result          res;
        logic [IDX_W-1:0] top;
        bit               idx_ok;
        res         = '0;
        res.status  = ST_INVALID;
        res.granted = rq.idx;
        idx_ok      = int'(rq.idx) < pool_size;
        case (rq.req)
            REQ_ACQUIRE: begin
                res.granted = '0;
                if (pool_depth == 0) begin
                    res.status = ST_NO_FREE;
                    if (pool_refused != '1) pool_refused++;
                end else begin
                    pool_depth--;
                    top            = pool_stack[pool_depth];
                    pool_busy[top] = 1'b1;
                    pool_len[top]  = '0;
                    res.granted    = top;
                    res.status     = ST_OK;
                    if (pool_size - pool_depth > pool_peak) pool_peak = pool_size - pool_depth;
                end
            end
            REQ_RELEASE: begin
                if (idx_ok && pool_busy[rq.idx] && pool_depth < pool_size) begin
                    pool_busy[rq.idx]      = 1'b0;
                    pool_stack[pool_depth] = rq.idx;
                    pool_depth++;
                    res.status = ST_OK;
                end
            end
            REQ_SET_LEN: begin
                if (idx_ok && pool_busy[rq.idx]) begin
                    res.len = (rq.want <= {16'h0, blk_bytes}) ? rq.want[LEN_W-1:0] : blk_bytes;
                    pool_len[rq.idx] = res.len;
                    res.status = ST_OK;
                end
            end
            default: ;
        endcase
        res.free  = CNT_W'(pool_depth);
        res.used  = CNT_W'(pool_size - pool_depth);
        res.peak  = CNT_W'(pool_peak);
        res.fails = pool_refused;
        return res;
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (req_taken || !s_tvalid) begin
                req_taken = 1'b0;
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tdata  <= pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                got_r = m_tdata[$bits(t_result)-1:0];
                if (expected_replies.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("Unexpected result word %h", m_tdata);
                end else begin
                    exp_r = expected_replies.pop_front();
                    if (got_r.status != exp_r.status || got_r.granted != exp_r.granted ||
                        got_r.len != exp_r.len || got_r.free != exp_r.free ||
                        got_r.used != exp_r.used || got_r.peak != exp_r.peak ||
                        got_r.fails != exp_r.fails) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("Mismatch at %0t: status/index/len/free/used/peak/fails",
                                     $realtime);
                            $display("  expected %0d %0d %0d %0d %0d %0d %0d", exp_r.status,
                                     exp_r.granted, exp_r.len, exp_r.free, exp_r.used,
                                     exp_r.peak, exp_r.fails);
                            $display("  actual   %0d %0d %0d %0d %0d %0d %0d", got_r.status,
                                     got_r.granted, got_r.len, got_r.free, got_r.used,
                                     got_r.peak, got_r.fails);
                        end
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_reg(t_cfg_reg'(i_cfg_index), i_cfg_data);
            end
            if (s_tvalid && s_tready) begin
                exp_r = predict_reply(t_request'(s_tdata));
                expected_replies = {expected_replies, exp_r};
                if (exp_r.status == ST_OK) n_ok++;
                else if (exp_r.status == ST_NO_FREE) n_nofree++;
                else n_invalid++;
                n_reqs++;
                req_taken = 1'b1;
            end
        end
    end

    task automatic send(input logic [1:0] kind, input logic [5:0] idx, input logic [31:0] want);
        t_request rq;
        rq.req  = kind;
        rq.idx  = idx;
        rq.want = want;
        pending_reqs = {pending_reqs, rq};
    endtask

    task automatic drain_pool();
        while (pending_reqs.size() != 0 || s_tvalid || expected_replies.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg sel, input logic [15:0] val);
        drain_pool();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    task automatic random_segment(input int n_items);
        int          sent;
        int          burst;
        int          p_acq;
        int          r;
        logic [5:0]  idx;
        logic [31:0] want;
        case ($urandom_range(7))
            0:       write_reg(CFG_POOL_BLOCKS, 16'd1);
            1:       write_reg(CFG_POOL_BLOCKS, 16'd2);
            2:       write_reg(CFG_POOL_BLOCKS, 16'd64);
            3:       write_reg(CFG_POOL_BLOCKS, 16'd127);
            4:       write_reg(CFG_POOL_BLOCKS, 16'd0);
            default: write_reg(CFG_POOL_BLOCKS, 16'($urandom_range(3, 63)));
        endcase
        case ($urandom_range(4))
            0:       write_reg(CFG_BLOCK_BYTES, 16'd0);
            1:       write_reg(CFG_BLOCK_BYTES, 16'd1);
            2:       write_reg(CFG_BLOCK_BYTES, 16'hFFFF);
            default: write_reg(CFG_BLOCK_BYTES, 16'($urandom_range(0, 65535)));
        endcase
        sent  = 0;
        burst = 0;
        p_acq = 50;
        if ($urandom_range(99) < 30) begin
            repeat (pool_size + $urandom_range(1, 3)) begin
                send(REQ_ACQUIRE, 6'($urandom_range(63)), $urandom);
                sent++;
            end
        end
        while (sent < n_items) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                case ($urandom_range(2))
                    0:       p_acq = 85;
                    1:       p_acq = 50;
                    default: p_acq = 15;
                endcase
            end
            if ($urandom_range(99) < 85) idx = 6'($urandom_range(0, pool_size - 1));
            else idx = 6'($urandom_range(63));
            case ($urandom_range(3))
                0:       want = $urandom;
                1:       want = $urandom_range(0, int'(blk_bytes) + 2);
                2:       want = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
                default: want = $urandom_range(0, 65535);
            endcase
            r = $urandom_range(99);
            if (r < p_acq) send(REQ_ACQUIRE, 6'($urandom_range(63)), $urandom);
            else if (r < p_acq + (100 - p_acq) / 2) send(REQ_RELEASE, idx, want);
            else if ($urandom_range(9) != 0) send(REQ_SET_LEN, idx, want);
            else send(REQ_UNKNOWN, idx, want);
            burst--;
            sent++;
        end
    endtask

    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        send_idle_pct  = 25;
        recv_stall_pct = 88;
        pool_size      = POOL_RESET;
        blk_bytes      = BYTES_RESET;
        pool_reinit();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send(REQ_ACQUIRE, 6'd63, 32'hFFFF_FFFF);
        send(REQ_SET_LEN, 6'd0, 32'd0);
        send(REQ_SET_LEN, 6'd0, 32'hFFFF_FFFF);
        send(REQ_SET_LEN, 6'd0, 32'd2048);
        send(REQ_SET_LEN, 6'd0, 32'd2049);
        send(REQ_ACQUIRE, 6'd0, 32'd0);
        send(REQ_RELEASE, 6'd0, 32'd0);
        send(REQ_RELEASE, 6'd0, 32'd0);
        send(REQ_SET_LEN, 6'd0, 32'd5);
        send(REQ_SET_LEN, 6'd63, 32'd1);
        send(REQ_UNKNOWN, 6'd63, 32'hFFFF_FFFF);
        send(REQ_ACQUIRE, 6'd21, 32'h5555_AAAA);
        write_reg(CFG_POOL_BLOCKS, 16'd0);
        send(REQ_ACQUIRE, 6'd0, 32'd0);
        send(REQ_ACQUIRE, 6'd0, 32'd0);
        send(REQ_ACQUIRE, 6'd42, 32'hAAAA_5555);
        send(REQ_RELEASE, 6'd1, 32'd0);
        send(REQ_SET_LEN, 6'd63, 32'd7);
        send(REQ_RELEASE, 6'd0, 32'd0);
        write_reg(CFG_BLOCK_BYTES, 16'd0);
        send(REQ_ACQUIRE, 6'd0, 32'd0);
        send(REQ_SET_LEN, 6'd0, 32'hFFFF_FFFF);
        write_reg(CFG_BLOCK_BYTES, 16'hFFFF);
        write_reg(CFG_POOL_BLOCKS, 16'd127);
        send(REQ_ACQUIRE, 6'd0, 32'd0);
        send(REQ_SET_LEN, 6'd0, 32'hFFFF_FFFF);
        send(REQ_SET_LEN, 6'd0, 32'd65535);
        send(REQ_SET_LEN, 6'd0, 32'd0);
        write_reg(CFG_BLOCK_BYTES, 16'd1);
        send(REQ_SET_LEN, 6'd0, 32'd2);

        for (int ph = 0; ph < 3; ph++) begin
            drain_pool();
            case (ph)
                0: begin
                    send_idle_pct  = 25;
                    recv_stall_pct = 88;
                end
                1: begin
                    send_idle_pct  = 88;
                    recv_stall_pct = 25;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            repeat (4) random_segment(170);
        end
        drain_pool();
        errors += expected_replies.size();

        $display("Ran %0d requests across %0d register writes and three idling patterns.",
                 n_reqs, n_cfg);
        $display("Outcomes: %0d ok, %0d refused on an empty pool, %0d invalid.",
                 n_ok, n_nofree, n_invalid);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
